@@ rtl/core/button_press_classifier_key_queue_top_defines.svh @@
// Assertion macros used by the button press classifier RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef BUTTON_PRESS_CLASSIFIER_KEY_QUEUE_TOP_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_KEY_QUEUE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define BPCKQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// A condition that must be followed by another one on the next clock edge.
`define BPCKQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BPCKQ_ASSERT(lbl, clk, rst, prop, msg)
`define BPCKQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/core/bpckq_pkg.sv @@
// Shared types, constants and helpers of the button press classifier.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package bpckq_pkg;

   // Command codes carried by an input beat.
   localparam logic [2:0] CMD_TICK       = 3'd0;
   localparam logic [2:0] CMD_KEY_READ   = 3'd1;
   localparam logic [2:0] CMD_EVENT_POLL = 3'd2;
   localparam logic [2:0] CMD_RESET      = 3'd3;
   localparam logic [2:0] CMD_SET_BLOCK  = 3'd4;

   // Register file layout: one 32-bit word per register.
   localparam int         CSR_ADDR_W       = 4;
   localparam logic [1:0] CSR_DEBOUNCE     = 2'd0;
   localparam logic [1:0] CSR_LONG_PRESS   = 2'd1;
   localparam logic [1:0] CSR_BACK_PRESENT = 2'd2;

   localparam logic [15:0] DEF_DEBOUNCE     = 16'd20;
   localparam logic [15:0] DEF_LONG_PRESS   = 16'd750;
   localparam logic        DEF_BACK_PRESENT = 1'b1;

   localparam int         QUEUE_DEPTH_DEF = 8;
   localparam logic [7:0] COUNT_MAX       = 8'hFF;

   // Bit positions inside a queued key entry.
   localparam int KEY_ESC_BIT     = 1;
   localparam int KEY_PRESSED_BIT = 0;

   typedef struct packed {
      logic [15:0] debounce_time;
      logic [15:0] long_press_time;
      logic        back_present;
   } cfg_type;

   // Queue request from the tracker. Pair 0 is pushed before pair 1.
   typedef struct packed {
      logic       clear;
      logic       pop;
      logic [1:0] pair_valid;
      logic [1:0] pair_esc;
   } queue_op_type;

   typedef struct packed {
      logic valid;
      logic is_esc;
      logic pressed;
   } key_out_type;

   typedef struct packed {
      logic [15:0] knob_diff;
      logic        ev_ok;
      logic        ev_back;
      logic        ev_ok_long;
      logic [31:0] ev_delta;
      logic [7:0]  ok_count;
      logic [7:0]  back_count;
      logic [7:0]  ok_long_count;
   } event_out_type;

   // Adds up to three to an event count that stops at its maximum.
   function automatic logic [7:0] sat_add(input logic [7:0] count, input logic [1:0] amount);
      logic [8:0] sum;
      sum = {1'b0, count} + {7'd0, amount};
      return (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[7:0];
   endfunction

endpackage

@@ rtl/core/button_press_classifier_key_queue_top.sv @@
// Top level of the button press classifier with key queue: beat registers, register file.
// Depends on bpckq_pkg, bpckq_tracker, bpckq_key_queue and the assertion macro header.
`timescale 1ns / 1ps
`include "button_press_classifier_key_queue_top_defines.svh"

// Channel   Direction  Handshake         Payload
// req       in         req_valid/ready   cmd, now_ms, encoder_pos, levels, block_value
// rsp       out        rsp_valid/ready   diff, key entry, event record, queue count
// csr       in         APB psel/penable  debounce, long press time, back present
//
// A beat is captured in the input register; the tracker and the key queue act on
// it in one pass, and its result lands in the result register once that is free
// or being emptied, so one beat per cycle is sustained while rsp_ready stays high.
// Reset is synchronous and active high; it loads the register defaults and
// empties the queue at once. A stalled result holds only the input register;
// a new beat is still taken in the cycle the waiting result leaves.

module button_press_classifier_key_queue_top #(
   parameter int QUEUE_DEPTH = bpckq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_cmd,
   input  logic [31:0]                        req_now_ms,
   input  logic signed [31:0]                 req_encoder_pos,
   input  logic                               req_ok_level,
   input  logic                               req_back_level,
   input  logic                               req_block_value,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [15:0]                 rsp_knob_diff,
   output logic                               rsp_key_valid,
   output logic                               rsp_key_is_esc,
   output logic                               rsp_key_pressed,
   output logic                               rsp_ev_ok,
   output logic                               rsp_ev_back,
   output logic                               rsp_ev_ok_long,
   output logic signed [31:0]                 rsp_ev_delta,
   output logic [7:0]                         rsp_ok_count,
   output logic [7:0]                         rsp_back_count,
   output logic [7:0]                         rsp_ok_long_count,
   output logic [3:0]                         rsp_queue_count,

   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [bpckq_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import bpckq_pkg::*;

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   // Input register: one command waiting for its pass.
   logic        in_valid_ff, in_valid_in;
   logic [2:0]  req_cmd_ff;
   logic [31:0] req_now_ms_ff;
   logic [31:0] req_encoder_pos_ff;
   logic        req_ok_level_ff;
   logic        req_back_level_ff;
   logic        req_block_value_ff;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   event_out_type rsp_ev_ff;
   key_out_type   rsp_key_ff;
   logic [3:0]    rsp_queue_count_ff;

   cfg_type cfg_ff, cfg_in;

   logic              go;
   logic              req_take;
   logic              csr_write;
   queue_op_type      q_op;
   key_out_type       key_out;
   event_out_type     ev_out;
   logic [FILL_W-1:0] fill_next;

   // The held command runs when the result register is free or being emptied.
   assign go        = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || go;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take ? 1'b1 : (go ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_cmd_ff         <= req_cmd;
         req_now_ms_ff      <= req_now_ms;
         req_encoder_pos_ff <= req_encoder_pos;
         req_ok_level_ff    <= req_ok_level;
         req_back_level_ff  <= req_back_level;
         req_block_value_ff <= req_block_value;
      end
      if (go) begin
         rsp_ev_ff          <= ev_out;
         rsp_key_ff         <= key_out;
         rsp_queue_count_ff <= 4'(fill_next);
      end
   end

   bpckq_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .cmd         (req_cmd_ff),
      .now_ms      (req_now_ms_ff),
      .encoder_pos (req_encoder_pos_ff),
      .ok_level    (req_ok_level_ff),
      .back_level  (req_back_level_ff),
      .block_value (req_block_value_ff),
      .cfg         (cfg_ff),
      .q_op        (q_op),
      .ev_out      (ev_out)
   );

   bpckq_key_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_key_queue (
      .clock     (clock),
      .reset     (reset),
      .q_op      (q_op),
      .key_out   (key_out),
      .fill_next (fill_next)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_knob_diff     = rsp_ev_ff.knob_diff;
   assign rsp_key_valid     = rsp_key_ff.valid;
   assign rsp_key_is_esc    = rsp_key_ff.is_esc;
   assign rsp_key_pressed   = rsp_key_ff.pressed;
   assign rsp_ev_ok         = rsp_ev_ff.ev_ok;
   assign rsp_ev_back       = rsp_ev_ff.ev_back;
   assign rsp_ev_ok_long    = rsp_ev_ff.ev_ok_long;
   assign rsp_ev_delta      = rsp_ev_ff.ev_delta;
   assign rsp_ok_count      = rsp_ev_ff.ok_count;
   assign rsp_back_count    = rsp_ev_ff.back_count;
   assign rsp_ok_long_count = rsp_ev_ff.ok_long_count;
   assign rsp_queue_count   = rsp_queue_count_ff;

   // Register file. The port never stalls, so a write lands on the access cycle.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (paddr[3:2])
            CSR_DEBOUNCE:     cfg_in.debounce_time   = pwdata[15:0];
            CSR_LONG_PRESS:   cfg_in.long_press_time = pwdata[15:0];
            CSR_BACK_PRESENT: cfg_in.back_present    = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         CSR_DEBOUNCE:     prdata = {16'd0, cfg_ff.debounce_time};
         CSR_LONG_PRESS:   prdata = {16'd0, cfg_ff.long_press_time};
         CSR_BACK_PRESENT: prdata = {31'd0, cfg_ff.back_present};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time   <= DEF_DEBOUNCE;
         cfg_ff.long_press_time <= DEF_LONG_PRESS;
         cfg_ff.back_present    <= DEF_BACK_PRESENT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The queue never reports more entries than it can hold.
   `BPCKQ_ASSERT(a_fill_bound, clock, reset, fill_next <= QUEUE_DEPTH, "queue fill above depth")
   // A held command is not lost while the result side stalls.
   `BPCKQ_ASSERT_NEXT(a_item_held, clock, reset, in_valid_ff && !go, in_valid_ff, "input beat dropped")
   // Only a key read takes an entry out of the queue.
   `BPCKQ_ASSERT(a_key_on_read, clock, reset, !key_out.valid || (go && req_cmd_ff == CMD_KEY_READ), "key popped outside a key read")
   // A reset command always reports an empty queue.
   `BPCKQ_ASSERT_NEXT(a_reset_empties, clock, reset, go && req_cmd_ff == CMD_RESET, rsp_queue_count_ff == 4'd0, "queue not empty after reset command")

endmodule

@@ rtl/core/bpckq_key_queue.sv @@
// Key queue of the button press classifier: a flop ring that drops its oldest entry when full.
// Depends on bpckq_pkg.
`timescale 1ns / 1ps

module bpckq_key_queue #(
   parameter int DEPTH = bpckq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bpckq_pkg::queue_op_type        q_op,
   output bpckq_pkg::key_out_type         key_out,
   output logic [$clog2(DEPTH + 1) - 1:0] fill_next
);
   import bpckq_pkg::*;

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int SUM_W  = $clog2(DEPTH + 5);

   logic [1:0]        store_ff [DEPTH];
   logic [1:0]        store_in [DEPTH];
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic [1:0]        entry [4];
   logic [2:0]        n_push;
   logic [IDX_W-1:0]  wr_idx [5];
   logic [IDX_W-1:0]  hd_idx [5];
   logic [SUM_W-1:0]  fill_sum;
   logic [2:0]        drop;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   always_comb begin
      entry  = '{default: '0};
      n_push = '0;
      unique case (q_op.pair_valid)
         2'b11: begin
            entry[0] = {q_op.pair_esc[0], 1'b1};
            entry[1] = {q_op.pair_esc[0], 1'b0};
            entry[2] = {q_op.pair_esc[1], 1'b1};
            entry[3] = {q_op.pair_esc[1], 1'b0};
            n_push   = 3'd4;
         end
         2'b01: begin
            entry[0] = {q_op.pair_esc[0], 1'b1};
            entry[1] = {q_op.pair_esc[0], 1'b0};
            n_push   = 3'd2;
         end
         2'b10: begin
            entry[0] = {q_op.pair_esc[1], 1'b1};
            entry[1] = {q_op.pair_esc[1], 1'b0};
            n_push   = 3'd2;
         end
         default: begin
         end
      endcase

      wr_idx[0] = tail_ff;
      hd_idx[0] = head_ff;
      for (int k = 0; k < 4; k++) begin
         wr_idx[k+1] = wrap_inc(wr_idx[k]);
         hd_idx[k+1] = wrap_inc(hd_idx[k]);
      end

      // Each push past a full queue pushes the head on by one.
      fill_sum = SUM_W'(fill_ff) + SUM_W'(n_push);
      drop     = (fill_sum > SUM_W'(DEPTH)) ? 3'(fill_sum - SUM_W'(DEPTH)) : 3'd0;

      store_in = store_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      fill_in  = fill_ff;
      key_out  = '0;

      if (q_op.clear) begin
         head_in = '0;
         tail_in = '0;
         fill_in = '0;
      end else if (q_op.pop) begin
         if (fill_ff != '0) begin
            key_out.valid   = 1'b1;
            key_out.is_esc  = store_ff[head_ff][KEY_ESC_BIT];
            key_out.pressed = store_ff[head_ff][KEY_PRESSED_BIT];
            head_in         = hd_idx[1];
            fill_in         = fill_ff - 1'b1;
         end
      end else if (n_push != '0) begin
         // Later writes win where a small ring wraps onto itself.
         for (int k = 0; k < 4; k++) begin
            if (3'(k) < n_push) begin
               store_in[wr_idx[k]] = entry[k];
            end
         end
         tail_in = wr_idx[n_push];
         head_in = hd_idx[drop];
         fill_in = (fill_sum > SUM_W'(DEPTH)) ? FILL_W'(DEPTH) : FILL_W'(fill_sum);
      end
   end

   assign fill_next = fill_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

endmodule

@@ rtl/core/bpckq_tracker.sv @@
// Button and encoder tracker: press classification, encoder diff and event record.
// Depends on bpckq_pkg; drives the key queue through a queue_op_type request.
`timescale 1ns / 1ps

module bpckq_tracker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  logic [2:0]                cmd,
   input  logic [31:0]               now_ms,
   input  logic [31:0]               encoder_pos,
   input  logic                      ok_level,
   input  logic                      back_level,
   input  logic                      block_value,
   input  bpckq_pkg::cfg_type        cfg,
   output bpckq_pkg::queue_op_type   q_op,
   output bpckq_pkg::event_out_type  ev_out
);
   import bpckq_pkg::*;

   logic        ok_prev_ff, ok_prev_in;
   logic        back_prev_ff, back_prev_in;
   logic [31:0] ok_press_time_ff, ok_press_time_in;
   logic        ok_press_valid_ff, ok_press_valid_in;
   logic [31:0] back_press_time_ff, back_press_time_in;
   logic        long_fired_ff, long_fired_in;
   logic        blocked_ff, blocked_in;
   logic [31:0] last_pos_ff, last_pos_in;
   logic [15:0] diff_ff, diff_in;
   logic [2:0]  flags_ff, flags_in;
   logic [7:0]  cnt_ok_ff, cnt_ok_in;
   logic [7:0]  cnt_back_ff, cnt_back_in;
   logic [7:0]  cnt_long_ff, cnt_long_in;
   logic [31:0] delta_ff, delta_in;

   always_comb begin
      logic [15:0] move;
      logic [31:0] opt_mid;
      logic        valid_mid;
      logic        lf_mid;
      logic        fire_ok;
      logic        fire_long;
      logic        fire_back;

      move      = 16'(last_pos_ff - encoder_pos);
      opt_mid   = ok_press_time_ff;
      valid_mid = ok_press_valid_ff;
      lf_mid    = long_fired_ff;
      fire_ok   = 1'b0;
      fire_long = 1'b0;
      fire_back = 1'b0;

      ok_prev_in         = ok_prev_ff;
      back_prev_in       = back_prev_ff;
      ok_press_time_in   = ok_press_time_ff;
      ok_press_valid_in  = ok_press_valid_ff;
      back_press_time_in = back_press_time_ff;
      long_fired_in      = long_fired_ff;
      blocked_in         = blocked_ff;
      last_pos_in        = last_pos_ff;
      diff_in            = diff_ff;
      flags_in           = flags_ff;
      cnt_ok_in          = cnt_ok_ff;
      cnt_back_in        = cnt_back_ff;
      cnt_long_in        = cnt_long_ff;
      delta_in           = delta_ff;
      q_op               = '0;
      ev_out             = '0;

      if (go) begin
         unique case (cmd)
            CMD_TICK: begin
               // The encoder is followed in blocked mode as well.
               diff_in     = diff_ff + move;
               delta_in    = delta_ff + {{16{move[15]}}, move};
               last_pos_in = encoder_pos;

               if (!blocked_ff) begin
                  if (ok_level && !ok_prev_ff) begin
                     opt_mid   = now_ms;
                     valid_mid = 1'b1;
                     lf_mid    = 1'b0;
                  end
                  if (!ok_level && ok_prev_ff) begin
                     fire_ok   = !long_fired_ff &&
                                 ((now_ms - ok_press_time_ff) >= {16'd0, cfg.debounce_time});
                     opt_mid   = '0;
                     valid_mid = 1'b0;
                     lf_mid    = 1'b0;
                  end
                  fire_long = ok_level && !lf_mid && valid_mid &&
                              ((now_ms - opt_mid) >= {16'd0, cfg.long_press_time});

                  ok_press_time_in  = opt_mid;
                  ok_press_valid_in = valid_mid;
                  long_fired_in     = lf_mid || fire_long;
                  ok_prev_in        = ok_level;

                  if (cfg.back_present) begin
                     if (back_level && !back_prev_ff) begin
                        back_press_time_in = now_ms;
                     end
                     if (!back_level && back_prev_ff) begin
                        fire_back = (now_ms - back_press_time_ff) >=
                                    {16'd0, cfg.debounce_time};
                        back_press_time_in = '0;
                     end
                     back_prev_in = back_level;
                  end

                  flags_in    = flags_ff | {fire_long, fire_long || fire_back, fire_ok};
                  cnt_ok_in   = sat_add(cnt_ok_ff, {1'b0, fire_ok});
                  cnt_back_in = sat_add(cnt_back_ff,
                                        {fire_long && fire_back, fire_long ^ fire_back});
                  cnt_long_in = sat_add(cnt_long_ff, {1'b0, fire_long});

                  // A short press and a long press never fire on the same tick.
                  q_op.pair_valid = {fire_back, fire_ok || fire_long};
                  q_op.pair_esc   = {1'b1, fire_long};
               end else begin
                  ok_prev_in = ok_level;
                  if (cfg.back_present) begin
                     back_prev_in = back_level;
                  end
                  ok_press_time_in   = '0;
                  ok_press_valid_in  = 1'b0;
                  back_press_time_in = '0;
                  long_fired_in      = 1'b0;
               end
            end
            CMD_KEY_READ: begin
               ev_out.knob_diff = diff_ff;
               diff_in          = '0;
               q_op.pop         = 1'b1;
            end
            CMD_EVENT_POLL: begin
               ev_out.ev_ok         = flags_ff[0];
               ev_out.ev_back       = flags_ff[1];
               ev_out.ev_ok_long    = flags_ff[2];
               ev_out.ev_delta      = delta_ff;
               ev_out.ok_count      = cnt_ok_ff;
               ev_out.back_count    = cnt_back_ff;
               ev_out.ok_long_count = cnt_long_ff;
               flags_in             = '0;
               delta_in             = '0;
               cnt_ok_in            = '0;
               cnt_back_in          = '0;
               cnt_long_in          = '0;
            end
            CMD_RESET: begin
               flags_in           = '0;
               delta_in           = '0;
               cnt_ok_in          = '0;
               cnt_back_in        = '0;
               cnt_long_in        = '0;
               diff_in            = '0;
               q_op.clear         = 1'b1;
               ok_prev_in         = ok_level;
               back_prev_in       = cfg.back_present && back_level;
               ok_press_time_in   = ok_level ? now_ms : '0;
               ok_press_valid_in  = ok_level;
               back_press_time_in = (cfg.back_present && back_level) ? now_ms : '0;
               long_fired_in      = 1'b0;
               last_pos_in        = encoder_pos;
            end
            CMD_SET_BLOCK: begin
               blocked_in = block_value;
               if (block_value) begin
                  flags_in           = '0;
                  cnt_ok_in          = '0;
                  cnt_back_in        = '0;
                  cnt_long_in        = '0;
                  q_op.clear         = 1'b1;
                  ok_press_time_in   = '0;
                  ok_press_valid_in  = 1'b0;
                  back_press_time_in = '0;
                  long_fired_in      = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ok_prev_ff         <= 1'b0;
         back_prev_ff       <= 1'b0;
         ok_press_time_ff   <= '0;
         ok_press_valid_ff  <= 1'b0;
         back_press_time_ff <= '0;
         long_fired_ff      <= 1'b0;
         blocked_ff         <= 1'b0;
         last_pos_ff        <= '0;
         diff_ff            <= '0;
         flags_ff           <= '0;
         cnt_ok_ff          <= '0;
         cnt_back_ff        <= '0;
         cnt_long_ff        <= '0;
         delta_ff           <= '0;
      end else begin
         ok_prev_ff         <= ok_prev_in;
         back_prev_ff       <= back_prev_in;
         ok_press_time_ff   <= ok_press_time_in;
         ok_press_valid_ff  <= ok_press_valid_in;
         back_press_time_ff <= back_press_time_in;
         long_fired_ff      <= long_fired_in;
         blocked_ff         <= blocked_in;
         last_pos_ff        <= last_pos_in;
         diff_ff            <= diff_in;
         flags_ff           <= flags_in;
         cnt_ok_ff          <= cnt_ok_in;
         cnt_back_ff        <= cnt_back_in;
         cnt_long_ff        <= cnt_long_in;
         delta_ff           <= delta_in;
      end
   end

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for button_press_classifier_key_queue_top.
// Depends on bpckq_pkg and the block's RTL; a scoreboard class predicts every result beat.
`timescale 1ns / 1ps

module tb_top;
   import bpckq_pkg::*;

   localparam int          CYCLE_LIMIT   = 200000;
   localparam logic [2:0]  CMD_FIRST_UNUSED = CMD_SET_BLOCK + 3'd1;
   localparam logic [2:0]  CMD_LAST_CODE    = 3'b111;

   // One command beat as the sender offers it.
   typedef struct {
      logic [2:0]  cmd;
      logic [31:0] now_ms;
      logic [31:0] pos;
      logic        ok;
      logic        back;
      logic        blk;
   } command_type;

   // One result beat, field for field as the block reports it.
   typedef struct {
      logic [15:0] knob_diff;
      logic        key_valid;
      logic        key_is_esc;
      logic        key_pressed;
      logic        ev_ok;
      logic        ev_back;
      logic        ev_ok_long;
      logic [31:0] ev_delta;
      logic [7:0]  ok_count;
      logic [7:0]  back_count;
      logic [7:0]  ok_long_count;
      logic [3:0]  queue_count;
   } result_type;

   // Tracks the button and encoder state of the block, predicts one result per
   // accepted command and checks the result beats against those predictions in order.
   class key_event_scoreboard;
      logic [15:0] debounce_ms;
      logic [15:0] long_press_ms;
      logic        back_present;
      logic        ok_prev, back_prev, ok_press_valid, long_fired, blocked;
      logic [31:0] ok_press_ms, back_press_ms, last_pos, delta;
      logic [15:0] diff;
      logic        seen_ok, seen_back, seen_long;
      logic [7:0]  n_ok, n_back, n_long;
      logic [1:0]  key_fifo[$];
      result_type  expected_results[$];
      int          errors;

      function new();
         debounce_ms = DEF_DEBOUNCE;
         long_press_ms = DEF_LONG_PRESS;
         back_present = DEF_BACK_PRESENT;
         ok_prev = 0;
         back_prev = 0;
         blocked = 0;
         last_pos = '0;
         delta = '0;
         diff = '0;
         errors = 0;
         clear_presses();
         clear_events();
      endfunction

      function void clear_events();
         seen_ok = 0;
         seen_back = 0;
         seen_long = 0;
         n_ok = '0;
         n_back = '0;
         n_long = '0;
      endfunction

      function void clear_presses();
         ok_press_ms = '0;
         ok_press_valid = 0;
         back_press_ms = '0;
         long_fired = 0;
      endfunction

      function logic [7:0] bump(logic [7:0] n);
         return (n == COUNT_MAX) ? n : n + 8'd1;
      endfunction

      // A full queue loses its oldest entry to make room.
      function void push_key(logic [1:0] k);
         if (key_fifo.size() >= QUEUE_DEPTH_DEF)
            key_fifo.delete(0);
         key_fifo.push_back(k);
      endfunction

      function void push_press_release(logic esc);
         logic [1:0] k;
         k = '0;
         k[KEY_ESC_BIT] = esc;
         k[KEY_PRESSED_BIT] = 1'b1;
         push_key(k);
         k[KEY_PRESSED_BIT] = 1'b0;
         push_key(k);
      endfunction

      function void tick(command_type c);
         logic [31:0] raw;
         logic [15:0] m;
         raw = c.pos - last_pos;
         if (raw != '0) begin
            // The diff counts the other way round from the encoder.
            m = 16'(32'd0 - raw);
            diff = diff + m;
            delta = delta + {{16{m[15]}}, m};
            last_pos = c.pos;
         end
         if (blocked) begin
            ok_prev = c.ok;
            if (back_present)
               back_prev = c.back;
            clear_presses();
            return;
         end
         if (c.ok && !ok_prev) begin
            ok_press_ms = c.now_ms;
            ok_press_valid = 1;
            long_fired = 0;
         end
         if (!c.ok && ok_prev) begin
            if (!long_fired && (c.now_ms - ok_press_ms) >= {16'd0, debounce_ms}) begin
               seen_ok = 1;
               n_ok = bump(n_ok);
               push_press_release(1'b0);
            end
            ok_press_ms = '0;
            ok_press_valid = 0;
            long_fired = 0;
         end
         if (c.ok && !long_fired && ok_press_valid &&
             (c.now_ms - ok_press_ms) >= {16'd0, long_press_ms}) begin
            seen_back = 1;
            seen_long = 1;
            n_back = bump(n_back);
            n_long = bump(n_long);
            push_press_release(1'b1);
            long_fired = 1;
         end
         ok_prev = c.ok;
         if (back_present) begin
            if (c.back && !back_prev)
               back_press_ms = c.now_ms;
            if (!c.back && back_prev) begin
               if ((c.now_ms - back_press_ms) >= {16'd0, debounce_ms}) begin
                  seen_back = 1;
                  n_back = bump(n_back);
                  push_press_release(1'b1);
               end
               back_press_ms = '0;
            end
            back_prev = c.back;
         end
      endfunction

      function void note_command(command_type c);
         result_type r;
         logic [1:0] k;
         r = '{default: '0};
         case (c.cmd)
            CMD_TICK: tick(c);
            CMD_KEY_READ: begin
               r.knob_diff = diff;
               diff = '0;
               if (key_fifo.size() > 0) begin
                  k = key_fifo.pop_front();
                  r.key_valid = 1;
                  r.key_is_esc = k[KEY_ESC_BIT];
                  r.key_pressed = k[KEY_PRESSED_BIT];
               end
            end
            CMD_EVENT_POLL: begin
               r.ev_ok = seen_ok;
               r.ev_back = seen_back;
               r.ev_ok_long = seen_long;
               r.ev_delta = delta;
               r.ok_count = n_ok;
               r.back_count = n_back;
               r.ok_long_count = n_long;
               clear_events();
               delta = '0;
            end
            CMD_RESET: begin
               clear_events();
               delta = '0;
               diff = '0;
               key_fifo.delete();
               ok_prev = c.ok;
               back_prev = back_present ? c.back : 1'b0;
               ok_press_ms = ok_prev ? c.now_ms : '0;
               ok_press_valid = ok_prev;
               back_press_ms = back_prev ? c.now_ms : '0;
               long_fired = 0;
               last_pos = c.pos;
            end
            CMD_SET_BLOCK: begin
               blocked = c.blk;
               if (c.blk) begin
                  clear_events();
                  key_fifo.delete();
                  clear_presses();
               end
            end
            default: ;
         endcase
         r.queue_count = 4'(key_fifo.size());
         expected_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: result beat with none expected, actual queue_count %0d",
                     $time, got.queue_count);
            return;
         end
         want = expected_results.pop_front();
         compare_field("knob_diff", want.knob_diff, got.knob_diff);
         compare_field("key_valid", want.key_valid, got.key_valid);
         compare_field("key_is_esc", want.key_is_esc, got.key_is_esc);
         compare_field("key_pressed", want.key_pressed, got.key_pressed);
         compare_field("ev_ok", want.ev_ok, got.ev_ok);
         compare_field("ev_back", want.ev_back, got.ev_back);
         compare_field("ev_ok_long", want.ev_ok_long, got.ev_ok_long);
         compare_field("ev_delta", want.ev_delta, got.ev_delta);
         compare_field("ok_count", want.ok_count, got.ok_count);
         compare_field("back_count", want.back_count, got.back_count);
         compare_field("ok_long_count", want.ok_long_count, got.ok_long_count);
         compare_field("queue_count", want.queue_count, got.queue_count);
      endfunction

      function int pending_count();
         return expected_results.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_cmd = CMD_TICK;
   logic [31:0]           req_now_ms = '0;
   logic signed [31:0]    req_encoder_pos = '0;
   logic                  req_ok_level = 1'b0;
   logic                  req_back_level = 1'b0;
   logic                  req_block_value = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic signed [15:0]    rsp_knob_diff;
   logic                  rsp_key_valid, rsp_key_is_esc, rsp_key_pressed;
   logic                  rsp_ev_ok, rsp_ev_back, rsp_ev_ok_long;
   logic signed [31:0]    rsp_ev_delta;
   logic [7:0]            rsp_ok_count, rsp_back_count, rsp_ok_long_count;
   logic [3:0]            rsp_queue_count;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // Stimulus controls: steady turns off random idling on both sides for a
   // stretch, hold_request starts the one long receiver hold-off.
   logic                  steady = 1'b0;
   logic                  hold_request = 1'b0;
   logic                  rsp_hold = 1'b0;
   int                    cycles = 0;

   // Running time, encoder position and button levels of the random stimulus.
   logic [31:0]           gen_now;
   logic [31:0]           gen_pos;
   logic                  gen_ok;
   logic                  gen_back;

   key_event_scoreboard   sb;
   result_type            seen_result;

   button_press_classifier_key_queue_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH_DEF)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_now_ms(req_now_ms),
      .req_encoder_pos(req_encoder_pos),
      .req_ok_level(req_ok_level),
      .req_back_level(req_back_level),
      .req_block_value(req_block_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_knob_diff(rsp_knob_diff),
      .rsp_key_valid(rsp_key_valid),
      .rsp_key_is_esc(rsp_key_is_esc),
      .rsp_key_pressed(rsp_key_pressed),
      .rsp_ev_ok(rsp_ev_ok),
      .rsp_ev_back(rsp_ev_back),
      .rsp_ev_ok_long(rsp_ev_ok_long),
      .rsp_ev_delta(rsp_ev_delta),
      .rsp_ok_count(rsp_ok_count),
      .rsp_back_count(rsp_back_count),
      .rsp_ok_long_count(rsp_ok_long_count),
      .rsp_queue_count(rsp_queue_count),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: random stalls about 13 percent of the time, none while
   // steady is set, and a solid stall while the long hold-off runs.
   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && (steady || $urandom_range(0, 99) >= 13);
   end

   // The long hold-off counts its own cycles. The sender keeps offering beats
   // meanwhile, so the input and result registers fill and req_ready drops.
   initial begin
      do @(posedge clock); while (!hold_request);
      rsp_hold <= 1'b1;
      repeat (80) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Result monitor: every accepted result beat goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_result.knob_diff = rsp_knob_diff;
         seen_result.key_valid = rsp_key_valid;
         seen_result.key_is_esc = rsp_key_is_esc;
         seen_result.key_pressed = rsp_key_pressed;
         seen_result.ev_ok = rsp_ev_ok;
         seen_result.ev_back = rsp_ev_back;
         seen_result.ev_ok_long = rsp_ev_ok_long;
         seen_result.ev_delta = rsp_ev_delta;
         seen_result.ok_count = rsp_ok_count;
         seen_result.back_count = rsp_back_count;
         seen_result.ok_long_count = rsp_ok_long_count;
         seen_result.queue_count = rsp_queue_count;
         sb.check_result(seen_result);
      end
   end

   // Offers one command beat and returns at the edge that accepts it. It is
   // entered just after a rising edge, so valid can stay high from one beat to
   // the next; only a random idle, which steady turns off, lowers it in between.
   task automatic drive_beat(command_type c);
      while (!steady && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= c.cmd;
      req_now_ms <= c.now_ms;
      req_encoder_pos <= c.pos;
      req_ok_level <= c.ok;
      req_back_level <= c.back;
      req_block_value <= c.blk;
      do @(posedge clock); while (!req_ready);
      sb.note_command(c);
   endtask

   task automatic send(logic [2:0] cmd, logic [31:0] now_ms, logic [31:0] pos,
                       logic ok, logic back, logic blk);
      command_type c;
      c.cmd = cmd;
      c.now_ms = now_ms;
      c.pos = pos;
      c.ok = ok;
      c.back = back;
      c.blk = blk;
      drive_beat(c);
   endtask

   // Lowers valid and waits until every expected result has arrived, so the
   // block is idle before a register write or the end of the run.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_count() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready.
   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         CSR_DEBOUNCE:     sb.debounce_ms = value[15:0];
         CSR_LONG_PRESS:   sb.long_press_ms = value[15:0];
         CSR_BACK_PRESENT: sb.back_present = value[0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [15:0] debounce_ms, logic [15:0] long_ms, logic back_on);
      settle();
      csr_write(CSR_DEBOUNCE, {16'd0, debounce_ms});
      csr_write(CSR_LONG_PRESS, {16'd0, long_ms});
      csr_write(CSR_BACK_PRESENT, {31'd0, back_on});
   endtask

   // One random bit.
   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   // Mostly small steps in time, some long holds, and now and then a jump
   // anywhere so that the time wraps.
   function automatic logic [31:0] time_step();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return '0;
      if (r < 80)
         return $urandom_range(1, 60);
      if (r < 94)
         return $urandom_range(61, 1200);
      if (r < 99)
         return $urandom_range(1201, 70000);
      return $urandom;
   endfunction

   function automatic logic [31:0] next_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30)
         return gen_pos;
      if (r < 95)
         return gen_pos + 32'($urandom_range(0, 200)) - 32'd100;
      return $urandom;
   endfunction

   // Ticks toggle both buttons on every beat so events pile up fast enough to
   // drive the counters into saturation and keep the key queue overflowing.
   task automatic burst(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 5)
            send(CMD_KEY_READ, $urandom, $urandom, coin(), coin(), coin());
         gen_now = gen_now + $urandom_range(0, 30);
         gen_pos = next_position();
         gen_ok = !gen_ok;
         gen_back = !gen_back;
         send(CMD_TICK, gen_now, gen_pos, gen_ok, gen_back, coin());
      end
      send(CMD_EVENT_POLL, $urandom, $urandom, coin(), coin(), coin());
   endtask

   // Mostly ticks with plausible button activity; reads, polls, resets, block
   // mode changes and unused codes are mixed in with random payloads.
   task automatic random_phase(int count, int poll_pct);
      int r;
      logic blk;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < poll_pct) begin
            send(CMD_EVENT_POLL, $urandom, $urandom, coin(), coin(), coin());
         end else if (r < poll_pct + 12) begin
            send(CMD_KEY_READ, $urandom, $urandom, coin(), coin(), coin());
         end else if (r < poll_pct + 14) begin
            gen_ok = coin();
            gen_back = coin();
            gen_now = gen_now + time_step();
            send(CMD_RESET, gen_now, gen_pos, gen_ok, gen_back, coin());
         end else if (r < poll_pct + 17) begin
            // Leave block mode again soon after entering it.
            blk = sb.blocked ? ($urandom_range(0, 99) < 20) : ($urandom_range(0, 99) < 40);
            send(CMD_SET_BLOCK, $urandom, $urandom, coin(), coin(), blk);
         end else if (r < poll_pct + 19) begin
            send(3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE)),
                 $urandom, $urandom, coin(), coin(), coin());
         end else begin
            gen_now = gen_now + time_step();
            gen_pos = next_position();
            if ($urandom_range(0, 99) < 35)
               gen_ok = !gen_ok;
            if ($urandom_range(0, 99) < 35)
               gen_back = !gen_back;
            send(CMD_TICK, gen_now, gen_pos, gen_ok, gen_back, coin());
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset register values (20 ms, 750 ms, BACK on).
      send(CMD_KEY_READ, '0, '0, 0, 0, 0);
      send(CMD_EVENT_POLL, '0, '0, 0, 0, 0);
      // A press at time 0 is valid, so holding it to 750 ms fires a long press,
      // and the release after it gives no short press.
      send(CMD_TICK, 32'd0, 32'd0, 1, 0, 0);
      send(CMD_TICK, 32'd750, 32'd5, 1, 0, 0);
      send(CMD_TICK, 32'd800, 32'd5, 0, 0, 0);
      // One ms short of the debounce time, then exactly on it.
      send(CMD_TICK, 32'd1000, 32'd5, 1, 1, 0);
      send(CMD_TICK, 32'd1019, 32'd5, 0, 0, 0);
      send(CMD_TICK, 32'd1100, 32'd5, 1, 1, 0);
      send(CMD_TICK, 32'd1120, 32'd5, 0, 0, 0);
      // A press that spans the wrap of the ms time, with extreme positions.
      send(CMD_TICK, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0);
      send(CMD_TICK, 32'h0000_0013, 32'h8000_0000, 0, 0, 0);
      // BACK press and release overflow the queue, dropping its oldest entries.
      send(CMD_TICK, 32'h0000_0100, 32'hFFFF_FFFF, 0, 1, 0);
      send(CMD_TICK, 32'h0000_0200, 32'h0000_0000, 0, 0, 0);
      send(CMD_KEY_READ, '0, '0, 0, 0, 0);
      send(CMD_KEY_READ, '0, '0, 0, 0, 0);
      send(CMD_KEY_READ, '1, '1, 1, 1, 1);
      send(CMD_EVENT_POLL, '0, '0, 0, 0, 0);
      // A blocked tick latches the levels but forgets the press times, so the
      // later release is judged against time 0.
      send(CMD_SET_BLOCK, '0, '0, 0, 0, 1);
      send(CMD_TICK, 32'd300, 32'd9, 1, 1, 0);
      send(CMD_SET_BLOCK, '0, '0, 0, 0, 0);
      send(CMD_TICK, 32'd5000, 32'd9, 0, 0, 0);
      // Reset with both buttons held starts their press times at now.
      send(CMD_RESET, 32'd6000, 32'd123, 1, 1, 0);
      send(CMD_TICK, 32'd6750, 32'd123, 1, 1, 0);
      for (int u = CMD_FIRST_UNUSED; u <= CMD_LAST_CODE; u++)
         send(3'(u), '1, '1, 1, 1, 1);
      send(CMD_KEY_READ, '0, '0, 0, 0, 0);
      send(CMD_EVENT_POLL, '0, '0, 0, 0, 0);

      gen_now = 32'd7000;
      gen_pos = 32'd123;
      gen_ok = 1'b1;
      gen_back = 1'b1;

      // Zero debounce and an unreachable long press: short OK presses and BACK
      // releases saturate their counts. Both sides run without idling here.
      configure(16'd0, 16'hFFFF, 1'b1);
      steady <= 1'b1;
      burst(520);
      steady <= 1'b0;
      // Zero long press time: every OK press fires a long press at once.
      configure(16'd0, 16'd0, 1'b1);
      burst(520);

      // Random phases over several settings, extremes among them.
      configure(DEF_DEBOUNCE, DEF_LONG_PRESS, 1'b1);
      hold_request <= 1'b1;
      random_phase(130, 4);
      configure(16'hFFFF, 16'hFFFF, 1'b1);
      random_phase(130, 4);
      configure(16'd0, 16'd100, 1'b0);
      random_phase(130, 2);
      configure(16'($urandom_range(0, 60)), 16'($urandom_range(30, 400)), coin());
      random_phase(130, 6);

      settle();
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/bpckq_pkg.sv
rtl/core/bpckq_key_queue.sv
rtl/core/bpckq_tracker.sv
rtl/core/button_press_classifier_key_queue_top.sv
tb/sv/tb_top.sv
